>>> rtl/landing_pid_velocity_controller_unit_macros.svh
// Assertion macros shared by lpvc_ctrl.sv and lpvc_dp.sv.
`ifndef LANDING_PID_VELOCITY_CONTROLLER_UNIT_MACROS_SVH
`define LANDING_PID_VELOCITY_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LPVC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpvc: assertion failed");
`define LPVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpvc: assertion failed");
`else
`define LPVC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LPVC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/lpvc_pkg.sv
package lpvc_pkg;

   localparam int ERROR_FRAC_BITS = 16;
   localparam int MAX_IMAGE_SIZE  = 4096;

   localparam int E_W    = ERROR_FRAC_BITS + 2;   // error, Q1.F
   localparam int I_W    = ERROR_FRAC_BITS + 4;   // integral, Q3.F
   localparam int SIZE_W = 13;
   localparam int C_W    = 14;
   localparam int ALT_W  = 16;
   localparam int US_W   = 20;
   localparam int LIM_W  = 19;
   localparam int VEL_W  = 12;
   localparam int VD_W   = 9;
   localparam int D_W    = 32;
   localparam int ACC_W  = 34;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;

   localparam int DIV_N_W   = 48;
   localparam int DIV_D_W   = 20;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   localparam int EMAX = 1 << (ERROR_FRAC_BITS + 1);
   localparam int IMAX = (1 << (ERROR_FRAC_BITS + 3)) - 1;
   localparam logic [US_W-1:0]    US_PER_S = US_W'(1000000);
   localparam logic [DIV_N_W-1:0] D_SAT    = DIV_N_W'(64'd32767 << ERROR_FRAC_BITS);

   // one second = 2^6 * 15625; x / 15625 = (x * US_RECIP) >> 45, exact for x < 2^31
   localparam int          US_PRE_SH   = 6;
   localparam int          US_RECIP_SH = 45;
   localparam logic [31:0] US_RECIP    = 32'd2251799814;

   // altitude thresholds, mm
   localparam logic [ALT_W-1:0] ALT_TRACK_MIN = ALT_W'(100);
   localparam logic [ALT_W-1:0] ALT_SEARCH    = ALT_W'(800);
   localparam logic [ALT_W-1:0] ALT_MID       = ALT_W'(1500);
   localparam logic [ALT_W-1:0] ALT_HIGH_GAIN = ALT_W'(2000);
   localparam logic [ALT_W-1:0] ALT_HIGH      = ALT_W'(3000);
   localparam logic [ALT_W-1:0] ALT_LAND      = ALT_W'(150);

   // gains in thousandths, speed limits in mm/s
   localparam logic signed [11:0] KP_HIGH = 12'sd2000;
   localparam logic signed [11:0] KP_LOW  = 12'sd1500;
   localparam logic signed [9:0]  KI_HIGH = 10'sd500;
   localparam logic signed [9:0]  KI_LOW  = 10'sd300;
   localparam logic signed [9:0]  KD_HIGH = 10'sd300;
   localparam logic signed [9:0]  KD_LOW  = 10'sd200;
   localparam logic [10:0] VMAX_HIGH = 11'd2000;
   localparam logic [10:0] VMAX_LOW  = 11'd1500;

   localparam logic [VD_W-1:0] VD_TRACK_HIGH = VD_W'(400);
   localparam logic [VD_W-1:0] VD_TRACK_MID  = VD_W'(300);
   localparam logic [VD_W-1:0] VD_TRACK_LOW  = VD_W'(200);
   localparam logic [VD_W-1:0] VD_SEARCH     = VD_W'(150);
   localparam logic [VD_W-1:0] VD_DROP       = VD_W'(500);

   typedef enum logic [1:0] {
      MODE_TRACK  = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_DROP   = 2'd2
   } lpvc_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_INTEGRAL_LIMIT = 2'd2
   } lpvc_csr_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DECIDE,
      OP_ERR_DIV,
      OP_ERR_CAP,
      OP_INT_MUL,
      OP_INT_DIV,
      OP_INT_CAP,
      OP_DER_MUL1,
      OP_DER_MUL2,
      OP_DER_DIV,
      OP_DER_CAP,
      OP_DER_ZERO,
      OP_P_TERM,
      OP_SUM,
      OP_VEL,
      OP_EMIT
   } lpvc_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_ERR_DIV,
      S_ERR_WAIT,
      S_INT_MUL,
      S_INT_DIV,
      S_INT_CAP,
      S_DER_MUL1,
      S_DER_MUL2,
      S_DER_DIV,
      S_DER_WAIT,
      S_P_TERM,
      S_SUM,
      S_VEL,
      S_EMIT
   } lpvc_state_type;

   typedef struct packed {
      lpvc_op_type op;
      logic        axis;   // 0 x/east, 1 y/north
   } lpvc_cmd_type;

   typedef struct packed {
      logic tracking;
      logic us_zero;
      logic div_done;
      logic out_free;
   } lpvc_status_type;

endpackage

>>> rtl/lpvc_div.sv
module lpvc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpvc_pkg::DIV_N_W-1:0]  dividend,
   input  logic [lpvc_pkg::DIV_D_W-1:0]  divisor,
   output logic                          done,
   output logic [lpvc_pkg::DIV_N_W-1:0]  quotient
);
   import lpvc_pkg::*;

   // restoring divider, one quotient bit a cycle
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   dsr_ff;
   logic [DIV_N_W-1:0]   quo_ff;
   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W:0]     diff;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[DIV_N_W-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
         quo_ff <= {quo_ff[DIV_N_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/lpvc_ctrl.sv
`include "landing_pid_velocity_controller_unit_macros.svh"

module lpvc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  lpvc_pkg::lpvc_status_type status,
   output lpvc_pkg::lpvc_cmd_type    cmd
);
   import lpvc_pkg::*;

   lpvc_state_type state_ff, state_in;
   logic           axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_DECIDE;
         S_DECIDE: begin
            axis_in  = 1'b0;
            state_in = status.tracking ? S_ERR_DIV : S_EMIT;
         end
         S_ERR_DIV:  state_in = S_ERR_WAIT;
         S_ERR_WAIT: if (status.div_done) state_in = S_INT_MUL;
         S_INT_MUL:  state_in = S_INT_DIV;
         S_INT_DIV:  state_in = S_INT_CAP;
         S_INT_CAP:  state_in = S_DER_MUL1;
         S_DER_MUL1: state_in = status.us_zero ? S_P_TERM : S_DER_MUL2;
         S_DER_MUL2: state_in = S_DER_DIV;
         S_DER_DIV:  state_in = S_DER_WAIT;
         S_DER_WAIT: if (status.div_done) state_in = S_P_TERM;
         S_P_TERM:   state_in = S_SUM;
         S_SUM:      state_in = S_VEL;
         S_VEL: begin
            if (axis_ff) begin
               state_in = S_EMIT;
            end else begin
               axis_in  = 1'b1;
               state_in = S_ERR_DIV;
            end
         end
         S_EMIT:     if (status.out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = OP_NONE;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_LOAD;
         end
         S_DECIDE:   cmd.op = OP_DECIDE;
         S_ERR_DIV:  cmd.op = OP_ERR_DIV;
         S_ERR_WAIT: if (status.div_done) cmd.op = OP_ERR_CAP;
         S_INT_MUL:  cmd.op = OP_INT_MUL;
         S_INT_DIV:  cmd.op = OP_INT_DIV;
         S_INT_CAP:  cmd.op = OP_INT_CAP;
         S_DER_MUL1: cmd.op = status.us_zero ? OP_DER_ZERO : OP_DER_MUL1;
         S_DER_MUL2: cmd.op = OP_DER_MUL2;
         S_DER_DIV:  cmd.op = OP_DER_DIV;
         S_DER_WAIT: if (status.div_done) cmd.op = OP_DER_CAP;
         S_P_TERM:   cmd.op = OP_P_TERM;
         S_SUM:      cmd.op = OP_SUM;
         S_VEL:      cmd.op = OP_VEL;
         S_EMIT:     if (status.out_free) cmd.op = OP_EMIT;
         default:    cmd.op = OP_NONE;
      endcase
   end

   `LPVC_ASSERT_IMPLY(a_done_in_wait, clock, reset, status.div_done,
      state_ff == S_ERR_WAIT || state_ff == S_DER_WAIT)
   `LPVC_ASSERT_NEXT(a_accept_decides, clock, reset, req_tvalid && req_tready,
      state_ff == S_DECIDE)

endmodule

>>> rtl/lpvc_dp.sv
`include "landing_pid_velocity_controller_unit_macros.svh"

module lpvc_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [lpvc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpvc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [lpvc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  lpvc_pkg::lpvc_cmd_type          cmd,
   output lpvc_pkg::lpvc_status_type       status,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [lpvc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                      rsp_tuser,
   output logic                            div_start,
   output logic [lpvc_pkg::DIV_N_W-1:0]    div_dividend,
   output logic [lpvc_pkg::DIV_D_W-1:0]    div_divisor,
   input  logic [lpvc_pkg::DIV_N_W-1:0]    div_quotient,
   input  logic                            div_done
);
   import lpvc_pkg::*;

   logic [SIZE_W-1:0] cfg_w_ff, cfg_h_ff;
   logic [LIM_W-1:0]  cfg_lim_ff;

   logic              seen_ff;
   logic [C_W-1:0]    cx_ff, cy_ff;
   logic [ALT_W-1:0]  alt_ff;
   logic [US_W-1:0]   us_ff;

   logic signed [I_W-1:0]     integ_ff [2];
   logic signed [E_W-1:0]     prev_ff  [2];
   logic                      lost_ff, land_ff;
   logic signed [E_W-1:0]     e_ff;
   logic                      neg_ff;
   logic signed [DIV_N_W-1:0] prod_ff;
   logic [I_W-1:0]            iq_ff;
   logic signed [D_W-1:0]     d_ff;
   logic signed [ACC_W-1:0]   p_ff, acc_ff;
   logic signed [VEL_W-1:0]   vel_ff [2];

   logic                      rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff;
   logic [1:0]                rsp_tuser_ff;

   // mode and gain schedule
   logic                  tracking, searching, high;
   logic signed [11:0]    kp;
   logic signed [9:0]     ki, kd;
   logic [10:0]           vmax;
   logic [VD_W-1:0]       vd;
   lpvc_mode_type         mode;
   logic                  ax;

   assign ax        = cmd.axis;
   assign tracking  = seen_ff && (alt_ff > ALT_TRACK_MIN);
   assign searching = !tracking && (alt_ff > ALT_SEARCH);
   assign high      = alt_ff > ALT_HIGH_GAIN;
   assign kp        = high ? KP_HIGH : KP_LOW;
   assign ki        = high ? KI_HIGH : KI_LOW;
   assign kd        = high ? KD_HIGH : KD_LOW;
   assign vmax      = high ? VMAX_HIGH : VMAX_LOW;

   always_comb begin
      if (tracking) begin
         mode = MODE_TRACK;
         if (alt_ff > ALT_HIGH)     vd = VD_TRACK_HIGH;
         else if (alt_ff > ALT_MID) vd = VD_TRACK_MID;
         else                       vd = VD_TRACK_LOW;
      end else if (searching) begin
         mode = MODE_SEARCH;
         vd   = VD_SEARCH;
      end else begin
         mode = MODE_DROP;
         vd   = VD_DROP;
      end
   end

   // normalised error numerator
   logic [SIZE_W-1:0]  size_raw, size_eff;
   logic [C_W-1:0]     two_w, c_sel, emag;
   logic signed [C_W:0] ediff;

   assign size_raw = ax ? cfg_h_ff : cfg_w_ff;
   always_comb begin
      if (size_raw < SIZE_W'(2))                   size_eff = SIZE_W'(2);
      else if (size_raw > SIZE_W'(MAX_IMAGE_SIZE)) size_eff = SIZE_W'(MAX_IMAGE_SIZE);
      else                                         size_eff = size_raw;
   end
   assign two_w = {size_eff, 1'b0};
   assign c_sel = ax ? cy_ff : cx_ff;
   assign ediff = signed'({1'b0, c_sel}) - signed'({1'b0, two_w});
   assign emag  = ediff[C_W] ? C_W'(-ediff) : ediff[C_W-1:0];

   logic [DIV_N_W-1:0] prod_mag;
   assign prod_mag = prod_ff[DIV_N_W-1] ? DIV_N_W'(-prod_ff) : DIV_N_W'(prod_ff);

   // integral step |e*us| / 1e6, below 2^37: drop 2^6, then reciprocal of 15625
   logic [30:0] int_y;
   logic [62:0] int_qfull;
   assign int_y     = prod_mag[US_PRE_SH+30:US_PRE_SH];
   assign int_qfull = 63'(int_y) * 63'(US_RECIP);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_N_W'({emag, {ERROR_FRAC_BITS{1'b0}}});
      div_divisor  = DIV_D_W'(two_w);
      case (cmd.op)
         OP_ERR_DIV: div_start = 1'b1;
         OP_DER_DIV: begin
            div_start    = 1'b1;
            div_dividend = prod_mag;
            div_divisor  = us_ff;
         end
         default: ;
      endcase
   end

   // error saturation
   logic [E_W-1:0] e_pos, e_negm, e_val;
   assign e_pos  = (div_quotient > DIV_N_W'(EMAX - 1)) ? E_W'(EMAX - 1)
                                                       : div_quotient[E_W-1:0];
   assign e_negm = (div_quotient > DIV_N_W'(EMAX)) ? E_W'(EMAX) : div_quotient[E_W-1:0];
   assign e_val  = neg_ff ? (E_W'(0) - e_negm) : e_pos;

   // integral update and clamp
   logic signed [I_W:0] qi, isum, lim_s, inew;
   logic [LIM_W-1:0]    lim_u;
   assign qi    = neg_ff ? -signed'({1'b0, iq_ff})
                         :  signed'({1'b0, iq_ff});
   assign isum  = (I_W+1)'(integ_ff[ax]) + qi;
   assign lim_u = (cfg_lim_ff > LIM_W'(IMAX)) ? LIM_W'(IMAX) : cfg_lim_ff;
   assign lim_s = signed'((I_W+1)'(lim_u));
   always_comb begin
      if (isum > lim_s)       inew = lim_s;
      else if (isum < -lim_s) inew = -lim_s;
      else                    inew = isum;
   end

   // multipliers, each registered
   logic signed [E_W:0]          dlt;
   logic signed [E_W+US_W:0]     m_int;
   logic signed [E_W+10:0]       m_kd;
   logic signed [E_W+US_W+11:0]  m_us;
   logic signed [E_W+11:0]       m_kp;
   logic signed [I_W+9:0]        m_ki;
   logic signed [US_W:0]         us_s, ups_s;

   assign us_s  = signed'({1'b0, us_ff});
   assign ups_s = signed'({1'b0, US_PER_S});
   assign dlt   = (E_W+1)'(e_ff) - (E_W+1)'(prev_ff[ax]);
   assign m_int = (E_W+US_W+1)'(e_ff) * (E_W+US_W+1)'(us_s);
   assign m_kd  = (E_W+11)'(kd) * (E_W+11)'(dlt);
   assign m_us  = (E_W+US_W+12)'(signed'(prod_ff[E_W+10:0])) * (E_W+US_W+12)'(ups_s);
   assign m_kp  = (E_W+12)'(kp) * (E_W+12)'(e_ff);
   assign m_ki  = (I_W+10)'(ki) * (I_W+10)'(integ_ff[ax]);

   // derivative saturation
   logic [DIV_N_W-1:0] dmag;
   assign dmag = (div_quotient > D_SAT) ? D_SAT : div_quotient;

   // output scaling and speed limit
   logic [ACC_W-1:0]  amag, ash;
   logic [10:0]       vlim;
   assign amag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign ash  = amag >> ERROR_FRAC_BITS;
   assign vlim = (ash > ACC_W'(vmax)) ? vmax : ash[10:0];

   logic                land_next;
   logic [VEL_W-1:0]    vn, ve;
   assign land_next = land_ff || (alt_ff < ALT_LAND);
   assign vn = tracking ? (VEL_W'(0) - VEL_W'(vel_ff[1])) : '0;
   assign ve = tracking ? VEL_W'(vel_ff[0]) : '0;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff   <= SIZE_W'(640);
         cfg_h_ff   <= SIZE_W'(480);
         cfg_lim_ff <= LIM_W'(131072);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    cfg_w_ff   <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:   cfg_h_ff   <= csr_wdata[SIZE_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_lim_ff <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff[0] <= '0;
         integ_ff[1] <= '0;
         prev_ff[0]  <= '0;
         prev_ff[1]  <= '0;
         lost_ff     <= 1'b0;
         land_ff     <= 1'b0;
      end else begin
         case (cmd.op)
            OP_DECIDE: begin
               if (!tracking && (!searching || !lost_ff)) begin
                  integ_ff[0] <= '0;
                  integ_ff[1] <= '0;
                  prev_ff[0]  <= '0;
                  prev_ff[1]  <= '0;
               end
            end
            OP_INT_CAP: integ_ff[ax] <= I_W'(inew);
            OP_P_TERM:  prev_ff[ax]  <= e_ff;
            OP_EMIT: begin
               land_ff <= land_next;
               if (seen_ff)        lost_ff <= 1'b0;
               else if (searching) lost_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            seen_ff <= req_tuser;
            cx_ff   <= req_tdata[13:0];
            cy_ff   <= req_tdata[27:14];
            alt_ff  <= req_tdata[43:28];
            us_ff   <= (req_tdata[63:44] > US_PER_S) ? US_PER_S : req_tdata[63:44];
         end
         OP_ERR_DIV:  neg_ff  <= ediff[C_W];
         OP_ERR_CAP:  e_ff    <= signed'(e_val);
         OP_INT_MUL:  prod_ff <= DIV_N_W'(m_int);
         OP_INT_DIV: begin
            neg_ff <= prod_ff[DIV_N_W-1];
            iq_ff  <= I_W'(int_qfull[62:US_RECIP_SH]);
         end
         OP_DER_MUL1: prod_ff <= DIV_N_W'(m_kd);
         OP_DER_MUL2: prod_ff <= DIV_N_W'(m_us);
         OP_DER_DIV:  neg_ff  <= prod_ff[DIV_N_W-1];
         OP_DER_CAP:  d_ff    <= neg_ff ? -signed'(D_W'(dmag)) : signed'(D_W'(dmag));
         OP_DER_ZERO: d_ff    <= '0;
         OP_P_TERM:   p_ff    <= ACC_W'(m_kp);
         OP_SUM:      acc_ff  <= p_ff + ACC_W'(m_ki) + ACC_W'(d_ff);
         OP_VEL: vel_ff[ax] <= acc_ff[ACC_W-1] ? signed'(VEL_W'(0) - VEL_W'(vlim))
                                               : signed'(VEL_W'(vlim));
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_tdata_ff <= RSP_DATA_W'({land_next, vd, ve, vn});
         rsp_tuser_ff <= mode;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign status.tracking = tracking;
   assign status.us_zero  = (us_ff == '0);
   assign status.div_done = div_done;
   assign status.out_free = !rsp_tvalid_ff || rsp_tready;

   `LPVC_ASSERT_IMPLY(a_track_descent, clock, reset,
      rsp_tvalid_ff && rsp_tuser_ff == MODE_TRACK,
      rsp_tdata_ff[32:24] == VD_TRACK_HIGH || rsp_tdata_ff[32:24] == VD_TRACK_MID ||
      rsp_tdata_ff[32:24] == VD_TRACK_LOW)
   `LPVC_ASSERT_IMPLY(a_idle_axes_zero, clock, reset,
      rsp_tvalid_ff && rsp_tuser_ff != MODE_TRACK,
      rsp_tdata_ff[23:0] == '0)

endmodule

>>> rtl/landing_pid_velocity_controller_unit.sv
// Landing velocity controller: one tracking word per camera frame in, one
// north/east/down velocity command word out.
// req_ channel: tuser = target seen; tdata = centre x, centre y (quarter
//   pixels), altitude (mm), elapsed time (us). csr_ channel writes frame
//   width, frame height and the integral clamp; always ready, write only
//   while the block is idle.
// A tracking frame runs up to four 48-step divisions (error and derivative
//   per axis; the derivative ones are skipped with zero elapsed time) on
//   the shared restoring divider; the one-second divide of the integral is
//   a reciprocal multiply. A searching or final drop frame goes from the
//   decide step straight to emit. One frame at a time: the next is accepted
//   the cycle after the result is registered.
// Reset clears both PID loops, the search and land flags, and restores the
//   configuration defaults (640 x 480, clamp 2.0).
// A stalled rsp_ side holds the result word; a finished frame waits in the
//   controller until the output register is free, while req_tready stays
//   low.
module landing_pid_velocity_controller_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [13:0] center_x_qpx, [27:14] center_y_qpx, [43:28] altitude_mm,
   // [63:44] elapsed_us
   input  logic [lpvc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] target_seen
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [11:0] vel_north_mms, [23:12] vel_east_mms, [32:24] vel_down_mms,
   // [33] land_now, [39:34] zero
   output logic [lpvc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] mode: 0 tracking, 1 searching, 2 final drop
   output logic [1:0]                      rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lpvc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpvc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lpvc_pkg::*;

   lpvc_cmd_type        cmd;
   lpvc_status_type     status;
   logic                div_start, div_done;
   logic [DIV_N_W-1:0]  div_dividend, div_quotient;
   logic [DIV_D_W-1:0]  div_divisor;

   // registers take writes on any cycle
   assign csr_ready = 1'b1;

   lpvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lpvc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_quotient (div_quotient),
      .div_done     (div_done)
   );

   // shared divider for error and derivative
   lpvc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule
